// ----- rtl/vfa_pkg.sv -----
// Package for the three-component fixed-point vector ALU.
// Word and fraction widths, action and error codes, the pipeline stage record
// and the saturation helpers. Depends on nothing.
package vfa_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int PROD_BITS = 2 * WORD_BITS;
	localparam int WIDE_BITS = PROD_BITS + 2;
	localparam int NUM_BITS  = WORD_BITS + FRAC_BITS;
	localparam int TOL_BITS  = WORD_BITS - 1;
	localparam int ACT_BITS  = 4;
	localparam int ERR_BITS  = 2;

	localparam logic [TOL_BITS-1:0]  TOL_RESET = TOL_BITS'(1);
	localparam logic [WIDE_BITS-1:0] HALF_LSB  = WIDE_BITS'(1) << (FRAC_BITS - 1);
	localparam logic [WORD_BITS-1:0] WORD_MAX  = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic [WORD_BITS-1:0] WORD_MIN  = {1'b1, {(WORD_BITS-1){1'b0}}};

	typedef enum logic [ACT_BITS-1:0] {
		ACT_ADD       = 4'd0,
		ACT_SUB       = 4'd1,
		ACT_ELEMMUL   = 4'd2,
		ACT_SCALE     = 4'd3,
		ACT_DIVIDE    = 4'd4,
		ACT_NEGATE    = 4'd5,
		ACT_DOT       = 4'd6,
		ACT_CROSS     = 4'd7,
		ACT_LENGTH    = 4'd8,
		ACT_NORMALIZE = 4'd9,
		ACT_EQUAL     = 4'd10
	} action_t;

	typedef enum logic [ERR_BITS-1:0] {
		ERR_OK        = 2'd0,
		ERR_DIV_ZERO  = 2'd1,
		ERR_ZERO_NORM = 2'd2,
		ERR_SAT       = 2'd3
	} err_t;

	typedef struct packed {
		logic                 sat;
		logic [WORD_BITS-1:0] val;
	} sat_word_t;

	// record carried through the square root and divider stages
	typedef struct packed {
		logic                           vld;
		action_t                        act;
		logic [2:0][WORD_BITS-1:0]      r;
		logic [WORD_BITS-1:0]           sc;
		logic                           flag;
		logic                           sat;
		err_t                           err;
		logic [2:0]                     nneg;
		logic [2:0][NUM_BITS-1:0]       num;
		logic [WORD_BITS-1:0]           dvs;
		logic [PROD_BITS-1:0]           ss;
		logic [WORD_BITS+1:0]           srem;
		logic [WORD_BITS-1:0]           root;
		logic [2:0][WORD_BITS-1:0]      drem;
		logic [2:0][NUM_BITS-1:0]       quo;
	} stg_t;

	function automatic sat_word_t sat_to_word(input logic signed [WIDE_BITS-1:0] v);
		sat_word_t o;
		o.sat = (v[WIDE_BITS-1:WORD_BITS-1] != {(WIDE_BITS-WORD_BITS+1){v[WIDE_BITS-1]}});
		if (o.sat) begin
			o.val = v[WIDE_BITS-1] ? WORD_MIN : WORD_MAX;
		end else begin
			o.val = v[WORD_BITS-1:0];
		end
		return o;
	endfunction

	// round half up, drop the fraction, saturate
	function automatic sat_word_t round_sat(input logic signed [WIDE_BITS-1:0] v);
		logic signed [WIDE_BITS-1:0] t;
		t = v + $signed(HALF_LSB);
		return sat_to_word(t >>> FRAC_BITS);
	endfunction

	function automatic logic [WORD_BITS-1:0] mag_word(input logic signed [WORD_BITS-1:0] v);
		return v[WORD_BITS-1] ? WORD_BITS'(-v) : WORD_BITS'(v);
	endfunction

endpackage

// ----- rtl/vector3_fixed_point_alu.sv -----
// Three-component Q16.16 vector ALU, top level.
// Multiply stages, a pipelined square root and a pipelined divider.
// Depends on vfa_pkg.
//
// A new item may start in every cycle (busy is always low). Each item comes
// out with a one-cycle done strobe, having passed 4 stages of
// operand select, multiply, combine and round, 32 square root stages (one
// root bit each) and 48 divider stages (one quotient bit each), then the
// output register. Every action takes the full path, so results leave in
// the order items went in. The receiver cannot stall; results must be taken
// when done is high. Write tolerance only while no item is in flight.
module vector3_fixed_point_alu (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [vfa_pkg::ACT_BITS-1:0]          action,
	input  logic signed [vfa_pkg::WORD_BITS-1:0]  a_x,
	input  logic signed [vfa_pkg::WORD_BITS-1:0]  a_y,
	input  logic signed [vfa_pkg::WORD_BITS-1:0]  a_z,
	input  logic signed [vfa_pkg::WORD_BITS-1:0]  b_x,
	input  logic signed [vfa_pkg::WORD_BITS-1:0]  b_y,
	input  logic signed [vfa_pkg::WORD_BITS-1:0]  b_z,
	input  logic signed [vfa_pkg::WORD_BITS-1:0]  scalar_in,
	input  logic                                  tolerance_we,
	input  logic [vfa_pkg::TOL_BITS-1:0]          tolerance_wdata,
	output logic                                  done,
	output logic signed [vfa_pkg::WORD_BITS-1:0]  res_x,
	output logic signed [vfa_pkg::WORD_BITS-1:0]  res_y,
	output logic signed [vfa_pkg::WORD_BITS-1:0]  res_z,
	output logic signed [vfa_pkg::WORD_BITS-1:0]  res_scalar,
	output logic                                  equal_flag,
	output logic [vfa_pkg::ERR_BITS-1:0]          error_code
);
	import vfa_pkg::*;

	logic [TOL_BITS-1:0] tol_q;

	// stage 1: operand select
	logic                        vld_s1;
	action_t                     act_s1;
	logic signed [WORD_BITS-1:0] a_s1 [3];
	logic signed [WORD_BITS-1:0] b_s1 [3];
	logic signed [WORD_BITS-1:0] s_s1;
	logic signed [WORD_BITS-1:0] ma_s1 [6];
	logic signed [WORD_BITS-1:0] mb_s1 [6];
	logic signed [WORD_BITS-1:0] ma_d [6];
	logic signed [WORD_BITS-1:0] mb_d [6];
	action_t                     act_in;

	// stage 2: products
	logic                        vld_s2;
	action_t                     act_s2;
	logic signed [WORD_BITS-1:0] a_s2 [3];
	logic signed [WORD_BITS-1:0] b_s2 [3];
	logic signed [WORD_BITS-1:0] s_s2;
	logic signed [PROD_BITS-1:0] p_s2 [6];

	// stage 3: sums and differences
	logic                        vld_s3;
	action_t                     act_s3;
	logic signed [WORD_BITS-1:0] a_s3 [3];
	logic signed [WORD_BITS-1:0] s_s3;
	logic signed [WORD_BITS:0]   lin_s3 [3];
	logic signed [WIDE_BITS-1:0] wv_s3 [3];
	logic                        eq_s3;
	logic signed [WORD_BITS:0]   lin_d [3];
	logic signed [WIDE_BITS-1:0] wv_d [3];
	logic signed [WIDE_BITS-1:0] dsum_d;
	logic signed [WORD_BITS:0]   diff_d [3];
	logic [WORD_BITS:0]          dmag_d [3];
	logic                        eq_d;

	// stage 4: rounding and saturation, divider operands
	stg_t      st_s4;
	stg_t      st4_d;
	sat_word_t sw4;

	stg_t sq_s [WORD_BITS];
	stg_t dv_s [NUM_BITS];
	stg_t dv_in0;
	sat_word_t swl;

	// output
	stg_t                           fin;
	logic [2:0][WORD_BITS-1:0]      rout;
	logic                           fsat;
	err_t                           ferr;
	logic                           rnd [3];
	logic [NUM_BITS:0]              q1 [3];
	logic signed [WIDE_BITS-1:0]    qv [3];
	sat_word_t                      swq [3];
	logic                           done_q;
	logic [2:0][WORD_BITS-1:0]      r_q;
	logic [WORD_BITS-1:0]           sc_q;
	logic                           flag_q;
	err_t                           err_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (tolerance_we) begin
			tol_q <= tolerance_wdata;
		end
	end

	// multiplier operand routing
	always_comb begin
		act_in = action_t'(action);
		for (int i = 0; i < 6; i++) begin
			ma_d[i] = '0;
			mb_d[i] = '0;
		end
		unique case (act_in)
			ACT_ELEMMUL, ACT_DOT: begin
				ma_d[0] = a_x; mb_d[0] = b_x;
				ma_d[1] = a_y; mb_d[1] = b_y;
				ma_d[2] = a_z; mb_d[2] = b_z;
			end
			ACT_SCALE: begin
				ma_d[0] = a_x; mb_d[0] = scalar_in;
				ma_d[1] = a_y; mb_d[1] = scalar_in;
				ma_d[2] = a_z; mb_d[2] = scalar_in;
			end
			ACT_CROSS: begin
				ma_d[0] = a_y; mb_d[0] = b_z;
				ma_d[3] = a_z; mb_d[3] = b_y;
				ma_d[1] = a_z; mb_d[1] = b_x;
				ma_d[4] = a_x; mb_d[4] = b_z;
				ma_d[2] = a_x; mb_d[2] = b_y;
				ma_d[5] = a_y; mb_d[5] = b_x;
			end
			ACT_LENGTH, ACT_NORMALIZE: begin
				ma_d[0] = a_x; mb_d[0] = a_x;
				ma_d[1] = a_y; mb_d[1] = a_y;
				ma_d[2] = a_z; mb_d[2] = a_z;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		act_s1  <= act_in;
		a_s1[0] <= a_x; a_s1[1] <= a_y; a_s1[2] <= a_z;
		b_s1[0] <= b_x; b_s1[1] <= b_y; b_s1[2] <= b_z;
		s_s1    <= scalar_in;
		for (int i = 0; i < 6; i++) begin
			ma_s1[i] <= ma_d[i];
			mb_s1[i] <= mb_d[i];
		end
		act_s2 <= act_s1;
		a_s2   <= a_s1;
		b_s2   <= b_s1;
		s_s2   <= s_s1;
		for (int i = 0; i < 6; i++) begin
			p_s2[i] <= ma_s1[i] * mb_s1[i];
		end
		act_s3 <= act_s2;
		a_s3   <= a_s2;
		s_s3   <= s_s2;
		lin_s3 <= lin_d;
		wv_s3  <= wv_d;
		eq_s3  <= eq_d;
	end

	// stage 3 combine; unused products are zero so cross needs no select
	always_comb begin
		dsum_d = WIDE_BITS'(p_s2[0]) + WIDE_BITS'(p_s2[1]) + WIDE_BITS'(p_s2[2]);
		for (int i = 0; i < 3; i++) begin
			wv_d[i]   = WIDE_BITS'(p_s2[i]) - WIDE_BITS'(p_s2[i+3]);
			diff_d[i] = (WORD_BITS+1)'(a_s2[i]) - (WORD_BITS+1)'(b_s2[i]);
			dmag_d[i] = diff_d[i][WORD_BITS] ? (WORD_BITS+1)'(-diff_d[i])
			                                 : (WORD_BITS+1)'(diff_d[i]);
			unique case (act_s2)
				ACT_ADD:    lin_d[i] = (WORD_BITS+1)'(a_s2[i]) + (WORD_BITS+1)'(b_s2[i]);
				ACT_SUB:    lin_d[i] = diff_d[i];
				ACT_NEGATE: lin_d[i] = -(WORD_BITS+1)'(a_s2[i]);
				default:    lin_d[i] = '0;
			endcase
		end
		if (act_s2 == ACT_DOT || act_s2 == ACT_LENGTH || act_s2 == ACT_NORMALIZE) begin
			wv_d[0] = dsum_d;
		end
		eq_d = 1'b1;
		for (int i = 0; i < 3; i++) begin
			if (!(dmag_d[i] < (WORD_BITS+1)'(tol_q))) eq_d = 1'b0;
		end
	end

	// stage 4: final values for the short actions, divider setup
	always_comb begin
		st4_d     = '0;
		sw4       = '0;
		st4_d.vld = vld_s3;
		st4_d.act = act_s3;
		st4_d.err = ERR_OK;
		st4_d.dvs = mag_word(s_s3);
		for (int i = 0; i < 3; i++) begin
			st4_d.num[i]  = {mag_word(a_s3[i]), {FRAC_BITS{1'b0}}};
			st4_d.nneg[i] = a_s3[i][WORD_BITS-1] ^ (act_s3 == ACT_DIVIDE && s_s3[WORD_BITS-1]);
		end
		unique case (act_s3)
			ACT_ADD, ACT_SUB, ACT_NEGATE: begin
				for (int i = 0; i < 3; i++) begin
					sw4 = sat_to_word(WIDE_BITS'(lin_s3[i]));
					st4_d.r[i] = sw4.val;
					st4_d.sat  = st4_d.sat | sw4.sat;
				end
			end
			ACT_ELEMMUL, ACT_SCALE, ACT_CROSS: begin
				for (int i = 0; i < 3; i++) begin
					sw4 = round_sat(wv_s3[i]);
					st4_d.r[i] = sw4.val;
					st4_d.sat  = st4_d.sat | sw4.sat;
				end
			end
			ACT_DOT: begin
				sw4 = round_sat(wv_s3[0]);
				st4_d.sc  = sw4.val;
				st4_d.sat = sw4.sat;
			end
			ACT_LENGTH, ACT_NORMALIZE: begin
				st4_d.ss = wv_s3[0][PROD_BITS-1:0];
			end
			ACT_DIVIDE: begin
				if (s_s3 == '0) st4_d.err = ERR_DIV_ZERO;
			end
			ACT_EQUAL: begin
				st4_d.flag = eq_s3;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s4 <= '0;
		end else begin
			st_s4 <= st4_d;
		end
	end

	// square root, one root bit per stage
	for (genvar k = 0; k < WORD_BITS; k++) begin : g_sq
		stg_t                 sq_in;
		stg_t                 sq_nx;
		logic [WORD_BITS+1:0] rsh;
		logic [WORD_BITS+1:0] trial;
		if (k == 0) begin : g_first
			assign sq_in = st_s4;
		end else begin : g_next
			assign sq_in = sq_s[k-1];
		end
		always_comb begin
			sq_nx = sq_in;
			rsh   = {sq_in.srem[WORD_BITS-1:0], sq_in.ss[PROD_BITS-1-2*k -: 2]};
			trial = {sq_in.root, 2'b01};
			if (rsh >= trial) begin
				sq_nx.srem = rsh - trial;
				sq_nx.root = {sq_in.root[WORD_BITS-2:0], 1'b1};
			end else begin
				sq_nx.srem = rsh;
				sq_nx.root = {sq_in.root[WORD_BITS-2:0], 1'b0};
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_s[k] <= '0;
			end else begin
				sq_s[k] <= sq_nx;
			end
		end
	end

	// pick the divisor: the root for normalize, |scalar| for divide
	always_comb begin
		dv_in0 = sq_s[WORD_BITS-1];
		swl    = sat_to_word(WIDE_BITS'(sq_s[WORD_BITS-1].root));
		if (dv_in0.act == ACT_NORMALIZE) begin
			dv_in0.dvs = dv_in0.root;
			if (dv_in0.root == '0) dv_in0.err = ERR_ZERO_NORM;
		end
		if (dv_in0.act == ACT_LENGTH) begin
			dv_in0.sc  = swl.val;
			dv_in0.sat = swl.sat;
		end
	end

	// restoring divider, one quotient bit per stage, three lanes
	for (genvar j = 0; j < NUM_BITS; j++) begin : g_dv
		stg_t               dv_in;
		stg_t               dv_nx;
		logic [WORD_BITS:0] rsh [3];
		if (j == 0) begin : g_first
			assign dv_in = dv_in0;
		end else begin : g_next
			assign dv_in = dv_s[j-1];
		end
		always_comb begin
			dv_nx = dv_in;
			for (int i = 0; i < 3; i++) begin
				rsh[i] = {dv_in.drem[i], dv_in.num[i][NUM_BITS-1-j]};
				if (rsh[i] >= {1'b0, dv_in.dvs}) begin
					dv_nx.drem[i] = WORD_BITS'(rsh[i] - {1'b0, dv_in.dvs});
					dv_nx.quo[i]  = {dv_in.quo[i][NUM_BITS-2:0], 1'b1};
				end else begin
					dv_nx.drem[i] = rsh[i][WORD_BITS-1:0];
					dv_nx.quo[i]  = {dv_in.quo[i][NUM_BITS-2:0], 1'b0};
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[j] <= '0;
			end else begin
				dv_s[j] <= dv_nx;
			end
		end
	end

	// quotient rounding (nearest, ties away), sign, saturation, error merge
	always_comb begin
		fin  = dv_s[NUM_BITS-1];
		rout = fin.r;
		fsat = fin.sat;
		for (int i = 0; i < 3; i++) begin
			rnd[i] = ({fin.drem[i], 1'b0} >= {1'b0, fin.dvs});
			q1[i]  = {1'b0, fin.quo[i]} + (NUM_BITS+1)'(rnd[i]);
			qv[i]  = fin.nneg[i] ? -WIDE_BITS'(q1[i]) : WIDE_BITS'(q1[i]);
			swq[i] = sat_to_word(qv[i]);
		end
		if ((fin.act == ACT_DIVIDE || fin.act == ACT_NORMALIZE) && fin.err == ERR_OK) begin
			for (int i = 0; i < 3; i++) begin
				rout[i] = swq[i].val;
				fsat    = fsat | swq[i].sat;
			end
		end
		if (fin.err != ERR_OK) begin
			ferr = fin.err;
		end else begin
			ferr = fsat ? ERR_SAT : ERR_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin.vld;
		end
	end

	always_ff @(posedge clk) begin
		r_q    <= rout;
		sc_q   <= fin.sc;
		flag_q <= fin.flag;
		err_q  <= ferr;
	end

	assign done       = done_q;
	assign res_x      = r_q[0];
	assign res_y      = r_q[1];
	assign res_z      = r_q[2];
	assign res_scalar = sc_q;
	assign equal_flag = flag_q;
	assign error_code = err_q;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the three-component Q16.16 vector ALU.
// Drives directed and random vector operations, predicts each result in
// 128-bit arithmetic and checks it against the done strobe. Depends on vfa_pkg.
`timescale 1ns / 1ps

module tb_top;
	import vfa_pkg::*;

	typedef struct {
		logic [ACT_BITS-1:0]         act;
		logic signed [WORD_BITS-1:0] ax, ay, az, bx, by, bz, s;
	} vec_op_t;

	typedef struct {
		logic [WORD_BITS-1:0] rx, ry, rz, rs;
		logic                 flag;
		logic [ERR_BITS-1:0]  err;
	} vec_res_t;

	localparam int STALL_LIMIT = 3000;

	logic clk, arst_n, start, busy, done, equal_flag, tolerance_we;
	logic [ACT_BITS-1:0] action;
	logic signed [WORD_BITS-1:0] a_x, a_y, a_z, b_x, b_y, b_z, scalar_in;
	logic signed [WORD_BITS-1:0] res_x, res_y, res_z, res_scalar;
	logic [TOL_BITS-1:0] tolerance_wdata;
	logic [ERR_BITS-1:0] error_code;

	vec_op_t  op_q[$];
	vec_res_t want_q[$];
	logic [TOL_BITS-1:0] tol_copy;
	int idle_pct;
	int mism;
	int stall_cnt;
	bit took;

	vector3_fixed_point_alu dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .action(action),
		.a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
		.scalar_in(scalar_in), .tolerance_we(tolerance_we),
		.tolerance_wdata(tolerance_wdata), .done(done), .res_x(res_x), .res_y(res_y),
		.res_z(res_z), .res_scalar(res_scalar), .equal_flag(equal_flag),
		.error_code(error_code)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic logic [WORD_BITS-1:0] sat_w(input logic signed [127:0] v, inout bit sat);
		if (v > 128'sd2147483647) begin
			sat = 1;
			return WORD_MAX;
		end
		if (v < -128'sd2147483648) begin
			sat = 1;
			return WORD_MIN;
		end
		return v[WORD_BITS-1:0];
	endfunction

	function automatic logic [WORD_BITS-1:0] round_w(input logic signed [127:0] v, inout bit sat);
		return sat_w((v + (128'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS, sat);
	endfunction

	function automatic logic signed [127:0] mul_x(input logic signed [WORD_BITS-1:0] a,
		input logic signed [WORD_BITS-1:0] b);
		logic signed [127:0] wa, wb;
		wa = a;
		wb = b;
		return wa * wb;
	endfunction

	// quotient in Q format, rounded to nearest with ties away from zero
	function automatic logic [WORD_BITS-1:0] qdiv(input logic signed [WORD_BITS-1:0] num,
		input logic [63:0] den, input bit den_neg, inout bit sat);
		logic [127:0] n, q, r;
		logic signed [127:0] sq;
		n = (num < 0 ? 128'(-64'sd0 - 64'(num)) : 128'(64'(num))) << FRAC_BITS;
		q = n / den;
		r = n % den;
		if (r >= den - r) q = q + 1;
		sq = q;
		if ((num < 0) != den_neg) sq = -sq;
		return sat_w(sq, sat);
	endfunction

	function automatic logic [63:0] root_of(input logic [127:0] n);
		logic [127:0] t, acc;
		acc = 0;
		for (int b = 33; b >= 0; b--) begin
			t = acc | (128'd1 << b);
			if (t * t <= n) acc = t;
		end
		return acc[63:0];
	endfunction

	function automatic vec_res_t predict_vec(input vec_op_t o, input logic [TOL_BITS-1:0] tol);
		vec_res_t r;
		logic signed [WORD_BITS-1:0] a[3], b[3];
		logic signed [127:0] d, acc;
		logic [127:0] ss;
		logic [63:0] len, ma;
		bit sat;
		int p, q;
		a[0] = o.ax; a[1] = o.ay; a[2] = o.az;
		b[0] = o.bx; b[1] = o.by; b[2] = o.bz;
		r = '{rx: 0, ry: 0, rz: 0, rs: 0, flag: 0, err: ERR_OK};
		sat = 0;
		case (o.act)
			ACT_ADD, ACT_SUB, ACT_ELEMMUL, ACT_SCALE, ACT_NEGATE, ACT_CROSS,
			ACT_DIVIDE, ACT_NORMALIZE: begin
				logic [WORD_BITS-1:0] v[3];
				v = '{0, 0, 0};
				if (o.act == ACT_NORMALIZE) begin
					ss = 0;
					for (int i = 0; i < 3; i++) ss = ss + 128'(mul_x(a[i], a[i]));
					len = root_of(ss);
				end
				for (int i = 0; i < 3; i++) begin
					p = (i + 1) % 3;
					q = (i + 2) % 3;
					case (o.act)
						ACT_ADD:     begin d = a[i]; d = d + b[i]; v[i] = sat_w(d, sat); end
						ACT_SUB:     begin d = a[i]; d = d - b[i]; v[i] = sat_w(d, sat); end
						ACT_NEGATE:  begin d = a[i]; v[i] = sat_w(-d, sat); end
						ACT_ELEMMUL: v[i] = round_w(mul_x(a[i], b[i]), sat);
						ACT_SCALE:   v[i] = round_w(mul_x(a[i], o.s), sat);
						ACT_CROSS:
							v[i] = round_w(mul_x(a[p], b[q]) - mul_x(a[q], b[p]), sat);
						ACT_DIVIDE: begin
							if (o.s == 0) r.err = ERR_DIV_ZERO;
							else begin
								d = o.s;
								ma = d < 0 ? 64'(-d) : 64'(d);
								v[i] = qdiv(a[i], ma, o.s < 0, sat);
							end
						end
						default: begin
							if (len == 0) r.err = ERR_ZERO_NORM;
							else v[i] = qdiv(a[i], len, 1'b0, sat);
						end
					endcase
				end
				if (r.err == ERR_OK) begin
					r.rx = v[0]; r.ry = v[1]; r.rz = v[2];
				end
			end
			ACT_DOT: begin
				acc = mul_x(a[0], b[0]) + mul_x(a[1], b[1]) + mul_x(a[2], b[2]);
				r.rs = round_w(acc, sat);
			end
			ACT_LENGTH: begin
				ss = 0;
				for (int i = 0; i < 3; i++) ss = ss + 128'(mul_x(a[i], a[i]));
				d = 128'(root_of(ss));
				r.rs = sat_w(d, sat);
			end
			ACT_EQUAL: begin
				r.flag = 1;
				for (int i = 0; i < 3; i++) begin
					d = a[i];
					d = d - b[i];
					if (d < 0) d = -d;
					if (!(d < 128'(tol))) r.flag = 0;
				end
			end
			default: ;
		endcase
		if (sat && r.err == ERR_OK) r.err = ERR_SAT;
		return r;
	endfunction

	// accept an item and check a result at every rising edge
	always @(posedge clk) begin
		vec_op_t o;
		vec_res_t w;
		took = 0;
		if (arst_n) begin
			if (start && !busy) begin
				o = '{act: action, ax: a_x, ay: a_y, az: a_z, bx: b_x, by: b_y, bz: b_z,
					s: scalar_in};
				want_q.push_back(predict_vec(o, tol_copy));
				took = 1;
			end
			if (done) begin
				if (want_q.size() == 0) begin
					mism++;
					if (mism <= 10) $display("unexpected result transfer at %0t", $realtime);
				end else begin
					w = want_q.pop_front();
					if (w.rx !== res_x || w.ry !== res_y || w.rz !== res_z ||
						w.rs !== res_scalar || w.flag !== equal_flag || w.err !== error_code) begin
						mism++;
						if (mism <= 10)
							$display("mismatch: exp %h %h %h s=%h f=%b e=%0d got %h %h %h s=%h f=%b e=%0d",
								w.rx, w.ry, w.rz, w.rs, w.flag, w.err,
								res_x, res_y, res_z, res_scalar, equal_flag, error_code);
					end
				end
			end
			stall_cnt = (took || done) ? 0 : stall_cnt + 1;
			if (stall_cnt >= STALL_LIMIT && (op_q.size() > 0 || want_q.size() > 0)) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// driver: holds an item until its transfer, then maybe idles
	always @(negedge clk) begin
		vec_op_t o;
		if (arst_n && (!start || took)) begin
			if (op_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
				o = op_q.pop_front();
				action <= o.act;
				a_x <= o.ax; a_y <= o.ay; a_z <= o.az;
				b_x <= o.bx; b_y <= o.by; b_z <= o.bz;
				scalar_in <= o.s;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	function automatic logic signed [WORD_BITS-1:0] pick_val();
		case ($urandom_range(0, 7))
			0:       return WORD_MAX;
			1:       return WORD_MIN;
			2:       return 0;
			3:       return $urandom_range(0, 1) ? 1 : -1;
			4, 5:    return $signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic vec_op_t rand_op();
		vec_op_t o;
		o.act = ($urandom_range(0, 19) == 0) ? ACT_BITS'($urandom_range(11, 15))
			: ACT_BITS'($urandom_range(0, 10));
		o.ax = pick_val(); o.ay = pick_val(); o.az = pick_val();
		o.bx = pick_val(); o.by = pick_val(); o.bz = pick_val();
		o.s = pick_val();
		if (o.act == ACT_EQUAL && $urandom_range(0, 2) != 0) begin
			o.bx = o.ax + $signed($urandom_range(0, 1024)) - 512;
			o.by = o.ay + $signed($urandom_range(0, 1024)) - 512;
			o.bz = o.az + $signed($urandom_range(0, 1024)) - 512;
		end
		if (o.act == ACT_NORMALIZE && $urandom_range(0, 9) == 0) begin
			o.ax = 0; o.ay = 0; o.az = 0;
		end
		return o;
	endfunction

	task automatic add_op(input logic [ACT_BITS-1:0] act, input logic signed [WORD_BITS-1:0] ax,
		ay, az, bx, by, bz, s);
		op_q.push_back('{act: act, ax: ax, ay: ay, az: az, bx: bx, by: by, bz: bz, s: s});
	endtask

	task automatic drain();
		while (op_q.size() > 0 || want_q.size() > 0 || start) @(posedge clk);
	endtask

	task automatic write_tol(input logic [TOL_BITS-1:0] v);
		@(negedge clk);
		tolerance_we <= 1'b1;
		tolerance_wdata <= v;
		@(negedge clk);
		tolerance_we <= 1'b0;
		tol_copy = v;
	endtask

	initial begin
		logic [TOL_BITS-1:0] tols[4];
		int pcts[4];
		arst_n = 1'b0;
		start = 1'b0;
		tolerance_we = 1'b0;
		tolerance_wdata = '0;
		action = '0;
		{a_x, a_y, a_z, b_x, b_y, b_z, scalar_in} = '0;
		tol_copy = TOL_RESET;
		idle_pct = 0;
		mism = 0;
		stall_cnt = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, every action, divide by zero, zero normalize, saturation
		add_op(ACT_ADD, WORD_MAX, WORD_MIN, 65536, 1, -1, 65536, 0);
		add_op(ACT_SUB, WORD_MIN, WORD_MAX, 0, 1, -1, 0, 0);
		add_op(ACT_ELEMMUL, WORD_MAX, WORD_MIN, 98304, WORD_MAX, WORD_MIN, -32768, 0);
		add_op(ACT_ELEMMUL, 1, -1, 32768, 32768, 32768, 1, 0);
		add_op(ACT_SCALE, 65536, -131072, WORD_MAX, 0, 0, 0, 32'sh0002_0000);
		add_op(ACT_SCALE, 1, 3, -3, 0, 0, 0, 32768);
		add_op(ACT_DIVIDE, 65536, -65536, WORD_MIN, 0, 0, 0, 0);
		add_op(ACT_DIVIDE, 65536, -65536, WORD_MIN, 0, 0, 0, 196608);
		add_op(ACT_DIVIDE, WORD_MAX, WORD_MIN, 5, 0, 0, 0, 1);
		add_op(ACT_DIVIDE, 1, -1, 3, 0, 0, 0, WORD_MIN);
		add_op(ACT_NEGATE, WORD_MIN, WORD_MAX, 0, 0, 0, 0, 0);
		add_op(ACT_DOT, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 0);
		add_op(ACT_DOT, 65536, 131072, -65536, 65536, 65536, 65536, 0);
		add_op(ACT_CROSS, 65536, 0, 0, 0, 65536, 0, 0);
		add_op(ACT_CROSS, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, 0);
		add_op(ACT_LENGTH, 196608, 262144, 0, 0, 0, 0, 0);
		add_op(ACT_LENGTH, WORD_MIN, WORD_MIN, WORD_MIN, 0, 0, 0, 0);
		add_op(ACT_NORMALIZE, 0, 0, 0, 0, 0, 0, 0);
		add_op(ACT_NORMALIZE, 1, 0, 0, 0, 0, 0, 0);
		add_op(ACT_NORMALIZE, 196608, -262144, 0, 0, 0, 0, 0);
		add_op(ACT_EQUAL, 5, 5, 5, 5, 5, 5, 0);
		add_op(ACT_EQUAL, 5, 5, 5, 5, 6, 5, 0);
		add_op(ACT_EQUAL, WORD_MIN, 0, 0, WORD_MAX, 0, 0, 0);
		add_op(4'd11, 1, 2, 3, 4, 5, 6, 7);
		add_op(4'd15, -1, -1, -1, -1, -1, -1, -1);
		drain();

		tols = '{0, {TOL_BITS{1'b1}}, 65536, 1};
		pcts = '{0, 48, 10, 0};
		for (int ph = 0; ph < 4; ph++) begin
			write_tol(ph == 3 ? TOL_BITS'($urandom_range(0, 4096)) : tols[ph]);
			idle_pct = pcts[ph];
			repeat (180) op_q.push_back(rand_op());
			drain();
		end

		repeat (120) @(posedge clk);
		if (mism == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/vfa_pkg.sv
rtl/vector3_fixed_point_alu.sv
tb/tb_top.sv
